// ===== design/tfs_pkg.sv =====
// Shared constants, codes and types of the tagged frame synchroniser.
package tfs_pkg;

  // Byte buffer depth and its fill count width
  localparam int WINDOW_BYTES = 20;
  localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
  localparam int FRAME_BYTES  = 16;
  localparam int HEAD_BYTES   = 8;

  // Identifier slots: default count and number reachable through registers
  localparam int ID_SLOTS_DEF = 4;
  localparam int CFG_SLOTS    = 4;

  // APB address width: five word registers
  localparam int CFG_AW = 5;

  // Tag bytes in stream order
  localparam logic [7:0] TAG_B0 = 8'h44;
  localparam logic [7:0] TAG_B1 = 8'h33;
  localparam logic [7:0] TAG_B2 = 8'h22;
  localparam logic [7:0] TAG_B3 = 8'h11;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_EOS   = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_AW-3:0] {
    REG_ID_COUNT = 3'd0,
    REG_ID_SLOT0 = 3'd1,
    REG_ID_SLOT1 = 3'd2,
    REG_ID_SLOT2 = 3'd3,
    REG_ID_SLOT3 = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // APB request bundle handed to the register file
  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
  } apb_req_t;

  // One result item as held in the output register
  typedef struct packed {
    logic        frame_valid;
    logic [31:0] hdr_ident;
    logic [31:0] frame_offset;
    logic [63:0] payload;
    logic        locked;
    logic [31:0] discarded_bytes;
    logic [31:0] unknown_id_drops;
    logic [31:0] resync_count;
    logic [31:0] lock_count;
    logic [31:0] frame_count;
    logic [31:0] unconfirmed_drops;
  } result_t;

endpackage

// ===== design/tfs_if.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
interface tfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface tfs_out_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [31:0] hdr_ident;
  logic [31:0] frame_offset;
  logic [63:0] payload;
  logic        locked;
  logic [31:0] discarded_bytes;
  logic [31:0] unknown_id_drops;
  logic [31:0] resync_count;
  logic [31:0] lock_count;
  logic [31:0] frame_count;
  logic [31:0] unconfirmed_drops;

  modport source (
    output valid, output frame_valid, output hdr_ident, output frame_offset,
    output payload, output locked, output discarded_bytes, output unknown_id_drops,
    output resync_count, output lock_count, output frame_count,
    output unconfirmed_drops, input ready
  );
  modport sink (
    input valid, input frame_valid, input hdr_ident, input frame_offset,
    input payload, input locked, input discarded_bytes, input unknown_id_drops,
    input resync_count, input lock_count, input frame_count,
    input unconfirmed_drops, output ready
  );
endinterface

// ===== design/tfs_cfg.sv =====
// Identifier register file with APB access and the identifier match.
module tfs_cfg #(
  parameter int ID_SLOTS = tfs_pkg::ID_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tfs_pkg::apb_req_t apb,
  output logic [31:0]       prdata,
  input  logic [31:0]       head_id,
  output logic              id_hit
);
  import tfs_pkg::*;

  logic [2:0]        id_count_r;
  logic [31:0]       slot_r [ID_SLOTS];
  logic              wr;
  logic [CFG_AW-3:0] idx;

  assign wr  = apb.psel & apb.penable & apb.pwrite;
  assign idx = apb.paddr[CFG_AW-1:2];

  // Hold the identifier count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_count_r <= '0;
    end else if (wr && idx == REG_ID_COUNT) begin
      id_count_r <= apb.pwdata[2:0];
    end
  end

  // Hold the identifier slots; slots beyond the register map stay zero
  for (genvar g = 0; g < ID_SLOTS; g++) begin : g_slot
    if (g < CFG_SLOTS) begin : g_rw
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          slot_r[g] <= '0;
        end else if (wr && idx == (3'(REG_ID_SLOT0) + 3'(g))) begin
          slot_r[g] <= apb.pwdata;
        end
      end
    end else begin : g_zero
      assign slot_r[g] = '0;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (idx == REG_ID_COUNT) begin
      prdata = {29'd0, id_count_r};
    end
    for (int i = 0; i < ID_SLOTS; i++) begin
      if (i < CFG_SLOTS && idx == (3'(REG_ID_SLOT0) + 3'(i))) begin
        prdata = slot_r[i];
      end
    end
  end

  // Match the head identifier against the slots in use
  always_comb begin
    id_hit = 1'b0;
    for (int i = 0; i < ID_SLOTS; i++) begin
      if (3'(i) < id_count_r && slot_r[i] == head_id) begin
        id_hit = 1'b1;
      end
    end
  end

endmodule

// ===== design/tagged_frame_sync_framer_top.sv =====
// Top level of the tagged frame synchroniser: byte buffer, scan sequencer, outputs.
// An item is accepted in ST_IDLE, scanned in ST_SCAN and its result loaded in ST_FINISH.
// Each scan cycle runs one step of the rescan loop over the 20-byte buffer
// (drop one byte, drop to resync, take a frame, or stop). End of stream, reset and
// unused commands skip the scan. A result not yet taken holds the sequencer in its
// result cycle.
// Reset (rst_n low, synchronous) empties the buffer, unlocks, and clears offset,
// counters and identifier registers.
module tagged_frame_sync_framer_top #(
  parameter int ID_SLOTS = tfs_pkg::ID_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tfs_in_if.sink                     in_chan,
  tfs_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [tfs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import tfs_pkg::*;

  state_t                         state_r, state_nxt;
  logic [WINDOW_BYTES-1:0][7:0]   win_r, win_nxt;
  logic [FILL_W-1:0]              fill_r, fill_nxt;
  logic                           sync_r, sync_nxt;
  logic [31:0]                    offset_r, offset_nxt;
  logic [31:0]                    disc_r, disc_nxt;
  logic [31:0]                    unk_r, unk_nxt;
  logic [31:0]                    resync_r, resync_nxt;
  logic [31:0]                    lock_r, lock_nxt;
  logic [31:0]                    frame_r, frame_nxt;
  logic [31:0]                    unconf_r, unconf_nxt;
  logic                           em_valid_r, em_valid_nxt;
  logic [31:0]                    em_id_r, em_id_nxt;
  logic [31:0]                    em_off_r, em_off_nxt;
  logic [63:0]                    em_pay_r, em_pay_nxt;
  logic                           ov_r, ov_nxt;
  result_t                        res_r, res_nxt;

  apb_req_t    apb;
  logic [31:0] head_id;
  logic        id_hit;
  logic        tag0, tag16, cand;
  logic        drop1, drop16;
  cmd_t        cmd;

  // Register file and identifier match
  assign apb = '{psel: cfg_psel, penable: cfg_penable, pwrite: cfg_pwrite,
                 paddr: cfg_paddr, pwdata: cfg_pwdata};
  assign cfg_pready = 1'b1;

  tfs_cfg #(.ID_SLOTS(ID_SLOTS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .apb     (apb),
    .prdata  (cfg_prdata),
    .head_id (head_id),
    .id_hit  (id_hit)
  );

  // Look at the buffer head and at the byte after one frame
  assign head_id = {win_r[7], win_r[6], win_r[5], win_r[4]};
  assign tag0    = win_r[0] == TAG_B0 && win_r[1] == TAG_B1 &&
                   win_r[2] == TAG_B2 && win_r[3] == TAG_B3;
  assign tag16   = win_r[16] == TAG_B0 && win_r[17] == TAG_B1 &&
                   win_r[18] == TAG_B2 && win_r[19] == TAG_B3;
  assign cand    = tag0 && id_hit;
  assign cmd     = cmd_t'(in_chan.cmd);

  // Channel ports
  assign in_chan.ready              = (state_r == ST_IDLE);
  assign out_chan.valid             = ov_r;
  assign out_chan.frame_valid       = res_r.frame_valid;
  assign out_chan.hdr_ident         = res_r.hdr_ident;
  assign out_chan.frame_offset      = res_r.frame_offset;
  assign out_chan.payload           = res_r.payload;
  assign out_chan.locked            = res_r.locked;
  assign out_chan.discarded_bytes   = res_r.discarded_bytes;
  assign out_chan.unknown_id_drops  = res_r.unknown_id_drops;
  assign out_chan.resync_count      = res_r.resync_count;
  assign out_chan.lock_count        = res_r.lock_count;
  assign out_chan.frame_count       = res_r.frame_count;
  assign out_chan.unconfirmed_drops = res_r.unconfirmed_drops;

  // Sequencer: next state, buffer moves and counter updates
  always_comb begin
    state_nxt    = state_r;
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    sync_nxt     = sync_r;
    offset_nxt   = offset_r;
    disc_nxt     = disc_r;
    unk_nxt      = unk_r;
    resync_nxt   = resync_r;
    lock_nxt     = lock_r;
    frame_nxt    = frame_r;
    unconf_nxt   = unconf_r;
    em_valid_nxt = em_valid_r;
    em_id_nxt    = em_id_r;
    em_off_nxt   = em_off_r;
    em_pay_nxt   = em_pay_r;
    ov_nxt       = ov_r;
    res_nxt      = res_r;
    drop1        = 1'b0;
    drop16       = 1'b0;

    // Release the output register once taken
    if (ov_r && out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          em_valid_nxt = 1'b0;
          em_id_nxt    = '0;
          em_off_nxt   = '0;
          em_pay_nxt   = '0;
          state_nxt    = ST_FINISH;
          unique case (cmd)
            CMD_DATA: begin
              win_nxt[fill_r] = in_chan.data_byte;
              fill_nxt        = fill_r + FILL_W'(1);
              state_nxt       = ST_SCAN;
            end
            CMD_EOS, CMD_RESET: begin
              if (!sync_r && fill_r >= FILL_W'(HEAD_BYTES) && cand) begin
                unconf_nxt = unconf_r + 32'd1;
              end
              disc_nxt   = disc_r + 32'(fill_r);
              offset_nxt = (cmd == CMD_RESET) ? 32'd0 : offset_r + 32'(fill_r);
              fill_nxt   = '0;
              sync_nxt   = 1'b0;
            end
            CMD_NONE: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (sync_r) begin
          // Locked: every frame position must hold a candidate
          if (fill_r < FILL_W'(FRAME_BYTES)) begin
            state_nxt = ST_FINISH;
          end else if (!cand) begin
            resync_nxt = resync_r + 32'd1;
            sync_nxt   = 1'b0;
          end else begin
            drop16 = 1'b1;
          end
        end else begin
          // Searching: need a candidate and a tag right after it
          if (fill_r < FILL_W'(HEAD_BYTES)) begin
            state_nxt = ST_FINISH;
          end else if (!cand) begin
            if (tag0) begin
              unk_nxt = unk_r + 32'd1;
            end
            drop1 = 1'b1;
          end else if (fill_r < FILL_W'(WINDOW_BYTES)) begin
            state_nxt = ST_FINISH;
          end else if (!tag16) begin
            drop1 = 1'b1;
          end else begin
            sync_nxt = 1'b1;
            lock_nxt = lock_r + 32'd1;
            drop16   = 1'b1;
          end
        end

        // Drop one byte as discarded
        if (drop1) begin
          disc_nxt   = disc_r + 32'd1;
          offset_nxt = offset_r + 32'd1;
          fill_nxt   = fill_r - FILL_W'(1);
          win_nxt    = win_r >> 8;
        end

        // Take a frame off the head
        if (drop16) begin
          em_valid_nxt = 1'b1;
          em_id_nxt    = head_id;
          em_off_nxt   = offset_r;
          em_pay_nxt   = win_r[15:8];
          frame_nxt    = frame_r + 32'd1;
          offset_nxt   = offset_r + 32'(FRAME_BYTES);
          fill_nxt     = fill_r - FILL_W'(FRAME_BYTES);
          win_nxt      = win_r >> (8 * FRAME_BYTES);
        end
      end

      ST_FINISH: begin
        // Load the result once the output register is free
        if (!ov_r || out_chan.ready) begin
          ov_nxt                    = 1'b1;
          res_nxt.frame_valid       = em_valid_r;
          res_nxt.hdr_ident         = em_id_r;
          res_nxt.frame_offset      = em_off_r;
          res_nxt.payload           = em_pay_r;
          res_nxt.locked            = sync_r;
          res_nxt.discarded_bytes   = disc_r;
          res_nxt.unknown_id_drops  = unk_r;
          res_nxt.resync_count      = resync_r;
          res_nxt.lock_count        = lock_r;
          res_nxt.frame_count       = frame_r;
          res_nxt.unconfirmed_drops = unconf_r;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state, offset and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      sync_r     <= 1'b0;
      offset_r   <= '0;
      disc_r     <= '0;
      unk_r      <= '0;
      resync_r   <= '0;
      lock_r     <= '0;
      frame_r    <= '0;
      unconf_r   <= '0;
      em_valid_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      sync_r     <= sync_nxt;
      offset_r   <= offset_nxt;
      disc_r     <= disc_nxt;
      unk_r      <= unk_nxt;
      resync_r   <= resync_nxt;
      lock_r     <= lock_nxt;
      frame_r    <= frame_nxt;
      unconf_r   <= unconf_nxt;
      em_valid_r <= em_valid_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // Byte buffer, frame fields and output payload
  always_ff @(posedge clk) begin
    win_r    <= win_nxt;
    em_id_r  <= em_id_nxt;
    em_off_r <= em_off_nxt;
    em_pay_r <= em_pay_nxt;
    res_r    <= res_nxt;
  end

endmodule
